### rtl/clds_pkg.sv
// shared types and constants of the distance scanner
package clds_pkg;

	localparam int MAX_SENSORS = 4;
	localparam int SENSOR_W    = 4;
	localparam int SAMPLE_W    = 16;
	localparam int DIST_W      = 16;
	localparam int COUNT_W     = 5;
	localparam int LIMIT_W     = 17;
	localparam int IDX_W       = 3;
	localparam int MN_W        = 14;
	localparam int NUM_W       = 32;
	localparam int DIV_CNT_W   = 4;

	// x / 5 == (x * RECIP5) >> RECIP5_SHIFT for every 16 bit x
	localparam logic [15:0] RECIP5       = 16'd52429;
	localparam int          RECIP5_SHIFT = 18;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

	localparam logic [15:0]        PERIOD_RST = 16'd1;
	localparam logic [COUNT_W-1:0] ACTIVE_RST = 5'd1;
	localparam logic [15:0]        FSCALE_RST = 16'd4095;
	localparam logic [15:0]        NEAR_RST   = 16'd0;
	localparam logic [15:0]        FAR_RST    = 16'hFFFF;
	localparam logic [LIMIT_W-1:0] REJECT_OFF = 17'h1FFFF;

	typedef enum logic [IDX_W-1:0] {
		REG_PERIOD = 3'd0,
		REG_ACTIVE = 3'd1,
		REG_FSCALE = 3'd2,
		REG_NEAR   = 3'd3,
		REG_FAR    = 3'd4,
		REG_REJECT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        period_ticks;
		logic [COUNT_W-1:0] active_sensors;
		logic [15:0]        full_scale;
		logic [15:0]        near_distance;
		logic [15:0]        far_distance;
		logic [LIMIT_W-1:0] reject_beyond;
	} cfg_t;

	// one classified tick handed from the front to the back
	typedef struct packed {
		logic                measured;
		logic [SENSOR_W-1:0] meas_idx;
		logic [SAMPLE_W-1:0] sample;
		logic [SENSOR_W-1:0] enabled;
		logic                any_enabled;
	} job_t;

	typedef struct packed {
		logic                measured;
		logic [SENSOR_W-1:0] measured_sensor;
		logic [DIST_W-1:0]   distance;
		logic                distance_valid;
		logic [SENSOR_W-1:0] enabled_sensor;
		logic                any_enabled;
	} result_t;

	// queue status seen by its neighbours
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/clds_ifs.sv
// stream interfaces for sample words and result words
interface clds_sample_if import clds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface clds_result_if import clds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                measured;
	logic [SENSOR_W-1:0] measured_sensor;
	logic [DIST_W-1:0]   distance;
	logic                distance_valid;
	logic [SENSOR_W-1:0] enabled_sensor;
	logic                any_enabled;

	modport source (output valid, output measured, output measured_sensor, output distance,
		output distance_valid, output enabled_sensor, output any_enabled, input ready);
	modport sink (input valid, input measured, input measured_sensor, input distance,
		input distance_valid, input enabled_sensor, input any_enabled, output ready);
	modport monitor (input valid, input ready, input measured, input measured_sensor,
		input distance, input distance_valid, input enabled_sensor, input any_enabled);
endinterface

### rtl/clds_front.sv
// front end: tick acceptance, wait counting and round-robin sensor selection
module clds_front import clds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	clds_sample_if.sink       samples,
	input  q_stat_t           q_stat,
	output logic              push,
	output job_t              job
);

	logic [15:0]          wait_q;
	logic [SENSOR_W-1:0]  cur_q;
	logic                 started_q;

	logic [15:0]          wait_d;
	logic [SENSOR_W-1:0]  cur_d;
	logic                 started_d;
	logic [COUNT_W-1:0]   count;
	logic [COUNT_W-1:0]   cur_inc;
	logic                 meas;

	assign samples.ready = !q_stat.full;
	assign push          = samples.valid && samples.ready;

	always_comb begin
		count = cfg.active_sensors;
		if (count == '0)
			count = COUNT_W'(1);
		if (count > COUNT_W'(MAX_SENSORS))
			count = COUNT_W'(MAX_SENSORS);
		cur_inc   = {1'b0, cur_q} + COUNT_W'(1);
		wait_d    = wait_q;
		cur_d     = cur_q;
		started_d = started_q;
		meas      = 1'b0;
		if (wait_q != '0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			if (started_q) begin
				meas  = 1'b1;
				cur_d = (cur_inc >= count) ? '0 : cur_inc[SENSOR_W-1:0];
			end else begin
				cur_d = '0;
			end
			started_d = 1'b1;
			wait_d    = (cfg.period_ticks == '0) ? '0 : cfg.period_ticks - 16'd1;
		end
		job.measured    = meas;
		job.meas_idx    = meas ? cur_q : '0;
		job.sample      = samples.adc_sample;
		job.enabled     = cur_d;
		job.any_enabled = started_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q    <= '0;
			cur_q     <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			wait_q    <= wait_d;
			cur_q     <= cur_d;
			started_q <= started_d;
		end
	end

endmodule

### rtl/clds_fifo.sv
// two-entry queue of classified ticks between front and back
module clds_fifo import clds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    pop_job,
	output q_stat_t q_stat
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign pop_job      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/clds_back.sv
// back end: sample scaling with a radix-4 divider and the result register
module clds_back import clds_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  q_stat_t       q_stat,
	input  job_t          pop_job,
	output logic          pop,
	clds_result_if.source results
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_MN,
		B_PREP,
		B_MUL,
		B_DIV,
		B_FIN,
		B_DONE
	} state_t;

	state_t               state_q;
	logic                 out_v_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	job_t                 job_q;
	result_t              pend_q;
	result_t              res_q;
	logic [31:0]          prod5_q;
	logic                 fault_q;
	logic                 low_q;
	logic [15:0]          diff_q;
	logic [15:0]          mag_q;
	logic                 neg_q;
	logic [15:0]          den_q;
	logic [NUM_W-1:0]     num_q;
	logic [15:0]          rem_q;

	logic [15:0]          mx;
	logic                 out_free;
	logic [16:0]          span;
	logic [16:0]          t;
	logic [15:0]          r;
	logic [NUM_W-1:0]     n;
	logic signed [33:0]   qs;
	logic signed [33:0]   d;
	logic signed [33:0]   rej_ext;
	logic                 too_far;
	logic                 ok;
	logic [DIST_W-1:0]    dist_clamp;

	assign mx       = (cfg.full_scale == '0) ? 16'd1 : cfg.full_scale;
	assign out_free = !out_v_q || results.ready;
	assign pop      = (state_q == B_IDLE) && !q_stat.empty;
	assign span     = {1'b0, cfg.far_distance} - {1'b0, cfg.near_distance};

	// two restoring division steps per cycle
	always_comb begin
		r = rem_q;
		n = num_q;
		t = '0;
		for (int i = 0; i < 2; i++) begin
			t = {r, n[NUM_W-1]};
			n = {n[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				r    = 16'(t - {1'b0, den_q});
				n[0] = 1'b1;
			end else begin
				r = t[15:0];
			end
		end
	end

	// signed offset, limit check and clamp
	always_comb begin
		qs      = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		d       = $signed({18'd0, cfg.near_distance}) + qs;
		rej_ext = {{17{cfg.reject_beyond[LIMIT_W-1]}}, cfg.reject_beyond};
		too_far = (cfg.reject_beyond != REJECT_OFF) && (d > rej_ext);
		ok      = !fault_q && !too_far;
		if (!ok || d < 0)
			dist_clamp = '0;
		else if (d > 34'sd65535)
			dist_clamp = 16'hFFFF;
		else
			dist_clamp = d[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (out_v_q && results.ready && state_q != B_DONE)
				out_v_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty)
						state_q <= pop_job.measured ? B_MN : B_DONE;
				end
				B_MN:   state_q <= B_PREP;
				B_PREP: state_q <= B_MUL;
				B_MUL: begin
					cnt_q   <= '0;
					state_q <= (fault_q || low_q) ? B_FIN : B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_LAST)
						state_q <= B_FIN;
				end
				B_FIN:  state_q <= B_DONE;
				B_DONE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q                  <= pop_job;
				pend_q.measured        <= 1'b0;
				pend_q.measured_sensor <= '0;
				pend_q.distance        <= '0;
				pend_q.distance_valid  <= 1'b0;
				pend_q.enabled_sensor  <= pop_job.enabled;
				pend_q.any_enabled     <= pop_job.any_enabled;
			end
			B_MN:   prod5_q <= mx * RECIP5;
			B_PREP: begin
				fault_q <= job_q.sample <= {4'd0, prod5_q[31:RECIP5_SHIFT+2]};
				low_q   <= job_q.sample <= {2'd0, prod5_q[31:RECIP5_SHIFT]};
				diff_q  <= job_q.sample - {2'd0, prod5_q[31:RECIP5_SHIFT]};
				den_q   <= mx - {2'd0, prod5_q[31:RECIP5_SHIFT]};
				neg_q   <= span[16];
				mag_q   <= span[16] ? 16'(-span) : span[15:0];
			end
			B_MUL: begin
				num_q <= (fault_q || low_q) ? '0 : diff_q * mag_q;
				rem_q <= '0;
			end
			B_DIV: begin
				num_q <= n;
				rem_q <= r;
			end
			B_FIN: begin
				pend_q.measured        <= 1'b1;
				pend_q.measured_sensor <= job_q.meas_idx;
				pend_q.distance        <= dist_clamp;
				pend_q.distance_valid  <= ok;
			end
			B_DONE: begin
				if (out_free)
					res_q <= pend_q;
			end
			default: ;
		endcase
	end

	assign results.valid           = out_v_q;
	assign results.measured        = res_q.measured;
	assign results.measured_sensor = res_q.measured_sensor;
	assign results.distance        = res_q.distance;
	assign results.distance_valid  = res_q.distance_valid;
	assign results.enabled_sensor  = res_q.enabled_sensor;
	assign results.any_enabled     = res_q.any_enabled;

endmodule

### rtl/current_loop_distance_scanner_top.sv
// top level of the round-robin 4-20 mA distance scanner
// Every sample word is one tick of the sensor that is currently enabled and gives
// exactly one result word. The front end counts the wait ticks and steps the scan
// round-robin over up to four sensors; it can run two ticks ahead of the back end,
// held in a two-entry queue. A tick that only counts down goes from the queue
// straight to the result register. A measuring tick passes through the back end in
// order: it is taken from the queue, then come the divide-by-five of full scale,
// the calibration terms, the 16x16 multiply and the radix-4 divider, then the
// offset, limit check and clamp, and last the step into the result register. A
// faulty reading or one at or below the 4 mA point skips the divider. The result
// register holds a finished word while the next tick is worked on.
module current_loop_distance_scanner_top import clds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// register write port
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [LIMIT_W-1:0] wr_data,
	// streams
	clds_sample_if.sink       samples,
	clds_result_if.source     results
);

	cfg_t    cfg_q;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    pop_job;
	q_stat_t q_stat;

	// shared calibration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks   <= PERIOD_RST;
			cfg_q.active_sensors <= ACTIVE_RST;
			cfg_q.full_scale     <= FSCALE_RST;
			cfg_q.near_distance  <= NEAR_RST;
			cfg_q.far_distance   <= FAR_RST;
			cfg_q.reject_beyond  <= REJECT_OFF;
		end else if (wr_en) begin
			case (wr_index)
				REG_PERIOD: cfg_q.period_ticks   <= wr_data[15:0];
				REG_ACTIVE: cfg_q.active_sensors <= wr_data[COUNT_W-1:0];
				REG_FSCALE: cfg_q.full_scale     <= wr_data[15:0];
				REG_NEAR:   cfg_q.near_distance  <= wr_data[15:0];
				REG_FAR:    cfg_q.far_distance   <= wr_data[15:0];
				REG_REJECT: cfg_q.reject_beyond  <= wr_data;
				default: ;
			endcase
		end
	end

	// tick classification and scan state
	clds_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.samples(samples),
		.q_stat (q_stat),
		.push   (push),
		.job    (push_job)
	);

	// decouples the front end from a busy divider
	clds_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_stat  (q_stat)
	);

	// scaling and result word
	clds_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.pop_job(pop_job),
		.pop    (pop),
		.results(results)
	);

endmodule

### rtl/clds_checker.sv
// port checks on the result stream of the scanner
module clds_checker import clds_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	clds_result_if.source results
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid && $stable({results.measured,
		results.measured_sensor, results.distance, results.distance_valid,
		results.enabled_sensor, results.any_enabled}))
		else $error("result word changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.measured |-> results.measured_sensor == '0 &&
		results.distance == '0 && !results.distance_valid)
		else $error("non-measuring word carries measurement fields");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.distance_valid |-> results.distance == '0)
		else $error("invalid reading with nonzero distance");

	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.measured |-> results.any_enabled)
		else $error("measurement before scan start");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.enabled_sensor < SENSOR_W'(MAX_SENSORS) &&
		results.measured_sensor < SENSOR_W'(MAX_SENSORS))
		else $error("sensor index out of range");

endmodule

bind current_loop_distance_scanner_top clds_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.results(results)
);

### test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the round-robin 4-20 mA distance scanner
module tb;
	import clds_pkg::*;

	localparam int               CLOCK_LIMIT   = 800000;
	localparam int               SETTLE_CYCLES = 30;
	localparam int               MAX_REPORTS   = 100;
	localparam int               PHASES        = 18;
	localparam int               PHASE_WORDS   = 77;
	// write indexes past the last register, ignored by the block
	localparam logic [IDX_W-1:0] REG_SPARE     = 3'd6;
	localparam logic [IDX_W-1:0] REG_LAST      = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_index;
	logic [LIMIT_W-1:0] wr_data;

	clds_sample_if smp ();
	clds_result_if res ();

	current_loop_distance_scanner_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (smp),
		.results  (res)
	);

	// shadow of the register file
	logic [15:0]        cfg_period;
	logic [4:0]         cfg_active;
	logic [15:0]        cfg_fscale;
	logic [15:0]        cfg_near;
	logic [15:0]        cfg_far;
	logic signed [16:0] cfg_reject;

	// shadow of the scan state
	logic [15:0] scan_wait;
	logic [3:0]  scan_sensor;
	logic        scan_running;

	logic [15:0] sample_q[$];   // sample words waiting to be sent
	result_t     distance_q[$]; // predicted result words in order

	logic taken;        // the sample word on the bus went in at the last rising edge
	logic hold_sender;  // sender stops offering words while set
	int   send_idle;    // percentage of cycles the sender idles
	int   recv_idle;    // percentage of cycles the receiver stalls
	int   mismatches;
	int   cycle_count;

	// clock, 20 ns period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sample to distance conversion, returns 1 for a good reading
	function automatic logic to_distance(input logic [15:0] sample, output logic [15:0] scaled);
		longint mx, mn, v, d, nr, fr, lim;
		mx     = (cfg_fscale == 16'd0) ? 1 : cfg_fscale;
		mn     = mx / 5;
		v      = sample;
		nr     = cfg_near;
		fr     = cfg_far;
		lim    = cfg_reject;
		scaled = '0;
		// fault at or below a quarter of the 4 mA point
		if (v <= mn / 4)
			return 1'b0;
		if (v <= mn)
			d = nr;
		else
			d = nr + ((v - mn) * (fr - nr)) / (mx - mn);
		// too-far check, any negative limit other than -1 rejects every non-negative distance
		if (lim != -1 && d > lim)
			return 1'b0;
		if (d < 0)
			d = 0;
		if (d > 65535)
			d = 65535;
		scaled = d[15:0];
		return 1'b1;
	endfunction

	// one tick of the scanner: count down, or measure and step to the next sensor
	task automatic step_scanner(input logic [15:0] sample, output result_t r);
		int          count;
		int          period;
		logic [15:0] scaled;
		r = '0;
		if (scan_wait != 16'd0) begin
			scan_wait = scan_wait - 16'd1;
		end else begin
			count  = (cfg_active == 5'd0) ? 1 : cfg_active;
			if (count > MAX_SENSORS)
				count = MAX_SENSORS;
			period = (cfg_period == 16'd0) ? 1 : cfg_period;
			if (scan_running) begin
				r.measured        = 1'b1;
				r.measured_sensor = scan_sensor;
				r.distance_valid  = to_distance(sample, scaled);
				r.distance        = r.distance_valid ? scaled : 16'd0;
				// wraps also when the sensor count shrank under the current index
				if (int'(scan_sensor) + 1 >= count)
					scan_sensor = 4'd0;
				else
					scan_sensor = scan_sensor + 4'd1;
			end else begin
				scan_sensor = 4'd0;
			end
			scan_running = 1'b1;
			scan_wait    = 16'(period - 1);
		end
		r.enabled_sensor = scan_sensor;
		r.any_enabled    = scan_running;
	endtask

	// sample word aimed at the conversion boundaries of the present full scale
	function automatic logic [15:0] pick_sample();
		int mx, mn;
		mx = (cfg_fscale == 16'd0) ? 1 : cfg_fscale;
		mn = mx / 5;
		case ($urandom_range(9))
			0: return 16'(mn / 4);
			1: return 16'(mn / 4 + 1);
			2: return 16'(mn);
			3: return 16'(mn + 1);
			4: return 16'(mx);
			5: return 16'($urandom_range(mn / 4));
			6: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			7: return 16'($urandom_range(65535, mx));
			default: return 16'($urandom_range(mx, mn));
		endcase
	endfunction

	task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		case (idx)
			REG_PERIOD: cfg_period = value[15:0];
			REG_ACTIVE: cfg_active = value[4:0];
			REG_FSCALE: cfg_fscale = value[15:0];
			REG_NEAR:   cfg_near   = value[15:0];
			REG_FAR:    cfg_far    = value[15:0];
			REG_REJECT: cfg_reject = value;
			default: ;
		endcase
	endtask

	// writes every register, with junk above the width of all but the reject limit, then a spare index
	task automatic apply_setup(input logic [15:0] per, input logic [4:0] act,
			input logic [15:0] fs, input logic [15:0] nr, input logic [15:0] fr,
			input logic [16:0] rj);
		set_reg(REG_PERIOD, {1'($urandom), per});
		set_reg(REG_ACTIVE, {12'($urandom), act});
		set_reg(REG_FSCALE, {1'($urandom), fs});
		set_reg(REG_NEAR, {1'($urandom), nr});
		set_reg(REG_FAR, {1'($urandom), fr});
		set_reg(REG_REJECT, rj);
		set_reg($urandom_range(1) ? REG_SPARE : REG_LAST, 17'($urandom));
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_setup();
		logic [15:0] per, fs, nr, fr;
		logic [4:0]  act;
		logic [16:0] rj;
		case ($urandom_range(9))
			0: per = 16'd0;
			1: per = 16'($urandom_range(12, 5));
			default: per = 16'($urandom_range(3, 1));
		endcase
		act = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(4, 1));
		case ($urandom_range(7))
			0: fs = 16'($urandom_range(30));
			1: fs = 16'hFFFF;
			2: fs = FSCALE_RST;
			default: fs = 16'($urandom);
		endcase
		if ($urandom_range(4) == 0) begin
			nr = NEAR_RST;
			fr = FAR_RST;
		end else begin
			nr = 16'($urandom);
			fr = 16'($urandom);
		end
		case ($urandom_range(5))
			0, 1: rj = REJECT_OFF;
			2: rj = {1'b1, 16'($urandom)};
			3: rj = 17'd65535;
			default: rj = 17'($urandom_range(65535));
		endcase
		apply_setup(per, act, fs, nr, fr, rj);
	endtask

	// waits until every word has gone in and every result has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || smp.valid || distance_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_items(input int n);
		repeat (n) sample_q.push_back(pick_sample());
		wait_idle();
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// driver: offers the next pending word at the falling edge, holds it until taken
	always @(negedge clk) begin
		if (smp.valid && !taken) begin
			// word still on offer
		end else if (arst_n && !hold_sender && sample_q.size() != 0
				&& $urandom_range(99) >= send_idle) begin
			smp.valid      <= 1'b1;
			smp.adc_sample <= sample_q[0];
		end else begin
			smp.valid <= 1'b0;
		end
		res.ready <= ($urandom_range(99) >= recv_idle);
	end

	// accepted sample words run through the predictor
	always @(posedge clk) begin : accept_side
		result_t predicted;
		taken <= arst_n && smp.valid && smp.ready;
		if (arst_n && smp.valid && smp.ready) begin
			step_scanner(smp.adc_sample, predicted);
			distance_q.push_back(predicted);
			void'(sample_q.pop_front());
		end
	end

	// monitor: every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (distance_q.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected", $time);
			end else begin
				want = distance_q.pop_front();
				check_field("measured", want.measured, res.measured);
				check_field("measured_sensor", want.measured_sensor, res.measured_sensor);
				check_field("distance", want.distance, res.distance);
				check_field("distance_valid", want.distance_valid, res.distance_valid);
				check_field("enabled_sensor", want.enabled_sensor, res.enabled_sensor);
				check_field("any_enabled", want.any_enabled, res.any_enabled);
			end
		end
	end

	// guard against a hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CLOCK_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0] first_words[8];
		logic [15:0] fault_words[4];
		int          guard;

		first_words = '{16'd0, 16'd0, 16'd204, 16'd205, 16'd819, 16'd820, 16'd4095, 16'hFFFF};
		fault_words = '{16'd0, 16'd1, 16'd2, 16'hFFFF};

		// every input known from time zero
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = REG_PERIOD;
		wr_data        = '0;
		smp.valid      = 1'b0;
		smp.adc_sample = '0;
		res.ready      = 1'b0;
		taken          = 1'b0;
		hold_sender    = 1'b0;
		send_idle      = 25;
		recv_idle      = 71;
		mismatches     = 0;
		cycle_count    = 0;

		// register and state values after reset
		cfg_period   = PERIOD_RST;
		cfg_active   = ACTIVE_RST;
		cfg_fscale   = FSCALE_RST;
		cfg_near     = NEAR_RST;
		cfg_far      = FAR_RST;
		cfg_reject   = REJECT_OFF;
		scan_wait    = '0;
		scan_sensor  = '0;
		scan_running = 1'b0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset setup: first word only starts the scan, then fault edge, 4 mA edge,
		// full scale and beyond full scale
		foreach (first_words[i]) sample_q.push_back(first_words[i]);
		wait_idle();

		// zero period, zero sensor count, zero full scale, falling slope, low limit
		apply_setup(16'd0, 5'd0, 16'd0, 16'hFFFF, 16'd0, 17'd100);
		foreach (fault_words[i]) sample_q.push_back(fault_words[i]);
		wait_idle();

		// sensor count above the maximum, widest full scale, highest limit
		apply_setup(16'd2, 5'd16, 16'hFFFF, 16'd0, 16'hFFFF, 17'd65535);
		run_items(6);

		// walk to the last sensor, then shrink the scan under it
		apply_setup(16'd1, 5'd4, FSCALE_RST, 16'd1000, 16'd3000, REJECT_OFF);
		guard = 0;
		while (scan_sensor != 4'd3 && guard < 8) begin
			run_items(1);
			guard++;
		end
		// limit below -1 rejects every reading
		apply_setup(16'd1, 5'd2, FSCALE_RST, 16'd1000, 16'd3000, 17'h1FFFB);
		run_items(3);

		// random part: receiver mostly stalled, then sender mostly idle, then full rate
		for (int p = 0; p < PHASES; p++) begin
			case (p / (PHASES / 3))
				0: begin
					send_idle = 25;
					recv_idle = 71;
				end
				1: begin
					send_idle = 71;
					recv_idle = 25;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			random_setup();
			if (p == 3) begin
				// sender stops mid-stream until the block has drained
				repeat (PHASE_WORDS) sample_q.push_back(pick_sample());
				while (sample_q.size() > PHASE_WORDS / 2) @(negedge clk);
				@(posedge clk);
				hold_sender = 1'b1;
				do
					@(negedge clk);
				while (smp.valid || distance_q.size() != 0);
				@(posedge clk);
				hold_sender = 1'b0;
				wait_idle();
			end else begin
				run_items(PHASE_WORDS);
			end
		end

		// longest period: at most one measurement, then a long count-down
		apply_setup(16'hFFFF, 5'd3, FSCALE_RST, 16'd500, 16'd9000, REJECT_OFF);
		run_items(8);

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && distance_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
rtl/clds_pkg.sv
rtl/clds_ifs.sv
rtl/clds_front.sv
rtl/clds_fifo.sv
rtl/clds_back.sv
rtl/current_loop_distance_scanner_top.sv
rtl/clds_checker.sv
test/tb.sv
